/* design/fbpa_pkg.sv */
// Shared constants and types for the fixed block pool allocator.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none
package fbpa_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int ADDR_W    = 32;
   localparam int SIZE_W    = 17;
   localparam int CNT_W     = 7;
   localparam int STAT_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int DIV_W     = SIZE_W + ((IDX_W > CNT_W) ? IDX_W : CNT_W);
   localparam int K_W       = $clog2(IDX_W + 1);

   typedef logic [STAT_W-1:0]    status_type;
   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [SIZE_W-1:0]    size_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_FULL   = 2'd1;
   localparam status_type ST_RANGE  = 2'd2;
   localparam status_type ST_DOUBLE = 2'd3;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam csr_idx_type REG_BASE  = 2'd0;
   localparam csr_idx_type REG_SIZE  = 2'd1;
   localparam csr_idx_type REG_ITEMS = 2'd2;

   localparam addr_type RST_BASE  = '0;
   localparam size_type RST_SIZE  = 17'd2048;
   localparam cnt_type  RST_ITEMS = 7'd64;

endpackage
`default_nettype wire

/* design/fbpa_req_if.sv */
// Request channel: valid/ready handshake carrying one allocate or free beat.
// Depends on fbpa_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface fbpa_req_if;
   import fbpa_pkg::*;

   logic     valid;
   logic     ready;
   logic     req_type;
   addr_type free_address;

   modport source (output valid, output req_type, output free_address, input ready);
   modport sink   (input valid, input req_type, input free_address, output ready);
endinterface
`default_nettype wire

/* design/fbpa_rsp_if.sv */
// Response channel: valid/ready handshake carrying one result beat.
// Depends on fbpa_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface fbpa_rsp_if;
   import fbpa_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   addr_type   block_address;
   addr_type   alloc_total;
   addr_type   free_total;
   cnt_type    blocks_outstanding;

   modport source (output valid, output status, output block_address, output alloc_total,
                   output free_total, output blocks_outstanding, input ready);
   modport sink   (input valid, input status, input block_address, input alloc_total,
                   input free_total, input blocks_outstanding, output ready);
endinterface
`default_nettype wire

/* design/fixed_block_pool_allocator.sv */
// Fixed block pool allocator: FIFO free list in a link RAM, serial index divider.
// Depends on fbpa_pkg, fbpa_req_if, fbpa_rsp_if.
//
//   channel   dir   handshake            payload
//   req_chan  in    valid/ready          req_type, free_address
//   rsp_chan  out   valid/ready          status, block_address, counters
//   csr_*     in    csr_wr_en            csr_index, csr_wdata
//
// Allocate: check with link RAM read, then update; the check alone answers when
// the pool is full. Free: check, range, one quotient bit per cycle, update; the
// range step answers when the address is out of range.
// Reset and a write to the base, size or item-count register rebuild the list at once through per-entry flags.
// A new request is taken while a result waits; a finishing step holds while
// the result register is still full.
`timescale 1ns / 1ps
`default_nettype none
module fixed_block_pool_allocator (
   input  wire                       clock,
   input  wire                       reset,
   fbpa_req_if.sink                  req_chan,
   fbpa_rsp_if.source                rsp_chan,
   input  wire                       csr_wr_en,
   input  wire fbpa_pkg::csr_idx_type csr_index,
   input  wire fbpa_pkg::addr_type   csr_wdata
);
   import fbpa_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHK   = 3'd1;
   localparam logic [2:0] S_ALOC  = 3'd2;
   localparam logic [2:0] S_RANGE = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_UPD   = 3'd5;

   function automatic cnt_type eff_count(input cnt_type raw);
      if (raw == '0) return CNT_W'(1);
      if (32'(raw) > MAX_ITEMS) return CNT_W'(MAX_ITEMS);
      return raw;
   endfunction

   logic [2:0] state_ff, state_in;
   addr_type   base_ff, base_in;
   size_type   size_ff, size_in;
   cnt_type    items_ff, items_in;

   idx_type                head_ff, head_in;
   idx_type                tail_ff, tail_in;
   logic                   empty_ff, empty_in;
   logic [MAX_ITEMS-1:0]   in_use_ff, in_use_in;
   logic [MAX_ITEMS-1:0]   link_vld_ff, link_vld_in;
   addr_type               alloc_cnt_ff, alloc_cnt_in;
   addr_type               free_cnt_ff, free_cnt_in;
   cnt_type                outs_ff, outs_in;

   logic                   type_ff, type_in;
   addr_type               addr_ff, addr_in;
   logic [IDX_W+SIZE_W-1:0] prod_ff, prod_in;
   logic [SIZE_W+CNT_W-1:0] span_ff, span_in;
   logic [ADDR_W:0]        off_ff, off_in;
   logic [DIV_W-1:0]       rem_ff, rem_in;
   idx_type                quo_ff, quo_in;
   logic [K_W-1:0]         k_ff, k_in;

   logic                   rsp_vld_ff, rsp_vld_in;
   status_type             rsp_status_ff, rsp_status_in;
   addr_type               rsp_addr_ff, rsp_addr_in;
   addr_type               rsp_alloc_ff;
   addr_type               rsp_free_ff;
   cnt_type                rsp_outs_ff;
   logic                   finish;

   idx_type                link_mem [MAX_ITEMS];
   idx_type                link_q_ff;
   logic                   link_re, link_we;
   idx_type                link_wa, link_wd;

   size_type               size_eff;
   cnt_type                cnt_eff;
   cnt_type                cnt_new;
   logic                   out_free;
   logic [IDX_W:0]         head_p1;
   idx_type                head_next;
   logic [DIV_W-1:0]       div_sh;
   logic [DIV_W:0]         div_trial;
   logic                   div_ge;

   assign size_eff  = (size_ff == '0) ? SIZE_W'(1) : size_ff;
   assign cnt_eff   = eff_count(items_ff);
   assign out_free  = !rsp_vld_ff || rsp_chan.ready;
   assign head_p1   = {1'b0, head_ff} + (IDX_W+1)'(1);
   assign head_next = link_vld_ff[head_ff] ? link_q_ff :
                      ((32'(head_p1) < 32'(cnt_eff)) ? IDX_W'(head_p1) : '0);
   assign div_sh    = DIV_W'(size_eff) << k_ff;
   assign div_trial = {1'b0, rem_ff} - {1'b0, div_sh};
   assign div_ge    = !div_trial[DIV_W];
   assign cnt_new   = eff_count((csr_index == REG_ITEMS) ? csr_wdata[CNT_W-1:0] : items_ff);

   assign req_chan.ready              = (state_ff == S_IDLE);
   assign rsp_chan.valid              = rsp_vld_ff;
   assign rsp_chan.status             = rsp_status_ff;
   assign rsp_chan.block_address      = rsp_addr_ff;
   assign rsp_chan.alloc_total        = rsp_alloc_ff;
   assign rsp_chan.free_total         = rsp_free_ff;
   assign rsp_chan.blocks_outstanding = rsp_outs_ff;

   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      size_in       = size_ff;
      items_in      = items_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      empty_in      = empty_ff;
      in_use_in     = in_use_ff;
      link_vld_in   = link_vld_ff;
      alloc_cnt_in  = alloc_cnt_ff;
      free_cnt_in   = free_cnt_ff;
      outs_in       = outs_ff;
      type_in       = type_ff;
      addr_in       = addr_ff;
      prod_in       = prod_ff;
      span_in       = span_ff;
      off_in        = off_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      k_in          = k_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_chan.ready;
      rsp_status_in = ST_OK;
      rsp_addr_in   = '0;
      finish        = 1'b0;
      link_re       = 1'b0;
      link_we       = 1'b0;
      link_wa       = tail_ff;
      link_wd       = quo_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               type_in  = req_chan.req_type;
               addr_in  = req_chan.free_address;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (type_ff == REQ_ALLOC) begin
               if (empty_ff) begin
                  if (out_free) begin
                     finish        = 1'b1;
                     rsp_status_in = ST_FULL;
                     state_in      = S_IDLE;
                  end
               end else begin
                  prod_in  = head_ff * size_eff;
                  link_re  = 1'b1;
                  state_in = S_ALOC;
               end
            end else begin
               span_in  = size_eff * cnt_eff;
               off_in   = {1'b0, addr_ff} - {1'b0, base_ff};
               state_in = S_RANGE;
            end
         end
         S_ALOC: begin
            if (out_free) begin
               finish             = 1'b1;
               rsp_addr_in        = ADDR_W'(base_ff + ADDR_W'(prod_ff));
               in_use_in[head_ff] = 1'b1;
               if (head_ff == tail_ff) begin
                  empty_in = 1'b1;
               end else begin
                  head_in = head_next;
               end
               alloc_cnt_in = alloc_cnt_ff + ADDR_W'(1);
               outs_in      = outs_ff + CNT_W'(1);
               state_in     = S_IDLE;
            end
         end
         S_RANGE: begin
            if (off_ff[ADDR_W] || (off_ff[ADDR_W-1:0] >= ADDR_W'(span_ff))) begin
               if (out_free) begin
                  finish        = 1'b1;
                  rsp_status_in = ST_RANGE;
                  state_in      = S_IDLE;
               end
            end else begin
               rem_in   = DIV_W'(off_ff);
               quo_in   = '0;
               k_in     = K_W'(IDX_W - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_ge) begin
               rem_in = div_trial[DIV_W-1:0];
            end
            quo_in = IDX_W'({quo_ff, div_ge});
            if (k_ff == '0) begin
               state_in = S_UPD;
            end else begin
               k_in = k_ff - K_W'(1);
            end
         end
         S_UPD: begin
            if (out_free) begin
               finish   = 1'b1;
               state_in = S_IDLE;
               if (!in_use_ff[quo_ff]) begin
                  rsp_status_in = ST_DOUBLE;
               end else begin
                  in_use_in[quo_ff] = 1'b0;
                  if (empty_ff) begin
                     head_in  = quo_ff;
                     empty_in = 1'b0;
                  end else begin
                     link_we              = 1'b1;
                     link_vld_in[tail_ff] = 1'b1;
                  end
                  tail_in     = quo_ff;
                  free_cnt_in = free_cnt_ff + ADDR_W'(1);
                  outs_in     = outs_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         rsp_vld_in = 1'b1;
      end

      if (csr_wr_en && (csr_index == REG_BASE || csr_index == REG_SIZE ||
                        csr_index == REG_ITEMS)) begin
         case (csr_index)
            REG_BASE:  base_in  = csr_wdata;
            REG_SIZE:  size_in  = csr_wdata[SIZE_W-1:0];
            REG_ITEMS: items_in = csr_wdata[CNT_W-1:0];
            default:   base_in  = base_ff;
         endcase
         head_in     = '0;
         tail_in     = IDX_W'(cnt_new - CNT_W'(1));
         empty_in    = 1'b0;
         in_use_in   = '0;
         link_vld_in = '0;
         outs_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (link_re) begin
         link_q_ff <= link_mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= RST_BASE;
         size_ff      <= RST_SIZE;
         items_ff     <= RST_ITEMS;
         head_ff      <= '0;
         tail_ff      <= IDX_W'(eff_count(RST_ITEMS) - CNT_W'(1));
         empty_ff     <= 1'b0;
         in_use_ff    <= '0;
         link_vld_ff  <= '0;
         alloc_cnt_ff <= '0;
         free_cnt_ff  <= '0;
         outs_ff      <= '0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         size_ff      <= size_in;
         items_ff     <= items_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         in_use_ff    <= in_use_in;
         link_vld_ff  <= link_vld_in;
         alloc_cnt_ff <= alloc_cnt_in;
         free_cnt_ff  <= free_cnt_in;
         outs_ff      <= outs_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff <= type_in;
      addr_ff <= addr_in;
      prod_ff <= prod_in;
      span_ff <= span_in;
      off_ff  <= off_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      k_ff    <= k_in;
      if (finish) begin
         rsp_status_ff <= rsp_status_in;
         rsp_addr_ff   <= rsp_addr_in;
         rsp_alloc_ff  <= alloc_cnt_in;
         rsp_free_ff   <= free_cnt_in;
         rsp_outs_ff   <= outs_in;
      end
   end

endmodule
`default_nettype wire

/* dv/fbpa_pool_checker.sv */
`timescale 1ns / 1ps
// Pool checker for the fixed block pool allocator: mirrors the free list from observed
// request beats and register writes, and compares each response beat in order.
// Depends on fbpa_pkg, fbpa_req_if and fbpa_rsp_if.
module fbpa_pool_checker (
   input  wire                   clock,
   input  wire                   reset,
   fbpa_req_if                   req_mon,
   fbpa_rsp_if                   rsp_mon,
   input  wire                   csr_wr_en,
   input  fbpa_pkg::csr_idx_type csr_index,
   input  fbpa_pkg::addr_type    csr_wdata,
   output int                    fail_count,
   output int                    pending
);
   import fbpa_pkg::*;

   typedef struct packed {
      status_type status;
      addr_type   block_address;
      addr_type   alloc_total;
      addr_type   free_total;
      cnt_type    blocks_outstanding;
   } pool_result_type;

   addr_type        pool_base;
   size_type        pool_blk_size;
   cnt_type         pool_item_count;
   idx_type         link_tbl [MAX_ITEMS];
   bit              busy_tbl [MAX_ITEMS];
   idx_type         head_idx;
   idx_type         tail_idx;
   bit              list_dry;
   addr_type        grants;
   addr_type        releases;
   cnt_type         held;
   pool_result_type due_results [$];
   int              report_count;

   function automatic int unsigned live_count();
      if (pool_item_count == 0) return 1;
      if (pool_item_count > MAX_ITEMS) return MAX_ITEMS;
      return 32'(pool_item_count);
   endfunction

   function automatic longint unsigned stride();
      return (pool_blk_size == 0) ? 64'd1 : 64'(pool_blk_size);
   endfunction

   function automatic void rebuild_free_list();
      int unsigned n;
      n = live_count();
      for (int i = 0; i < MAX_ITEMS; i++) begin
         link_tbl[i] = (i + 1 < n) ? idx_type'(i + 1) : '0;
         busy_tbl[i] = 1'b0;
      end
      head_idx = '0;
      tail_idx = idx_type'(n - 1);
      list_dry = 1'b0;
      held     = '0;
   endfunction

   function automatic pool_result_type serve_request(logic kind, addr_type addr);
      pool_result_type r;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned at;
      idx_type         slot;
      r        = '0;
      r.status = ST_OK;
      lo       = 64'(pool_base);
      at       = 64'(addr);
      if (kind == REQ_ALLOC) begin
         if (list_dry) begin
            r.status = ST_FULL;
         end else begin
            slot = head_idx;
            r.block_address = addr_type'(lo + 64'(slot) * stride());
            busy_tbl[slot] = 1'b1;
            if (head_idx == tail_idx) list_dry = 1'b1;
            else head_idx = link_tbl[slot];
            grants = grants + 1;
            held   = held + cnt_type'(1);
         end
      end else begin
         hi = lo + stride() * live_count();
         if (at < lo || at >= hi) begin
            r.status = ST_RANGE;
         end else begin
            slot = idx_type'((at - lo) / stride());
            if (!busy_tbl[slot]) begin
               r.status = ST_DOUBLE;
            end else begin
               busy_tbl[slot] = 1'b0;
               link_tbl[slot] = '0;
               // an empty list restarts from the returned block
               if (list_dry) begin
                  head_idx = slot;
                  list_dry = 1'b0;
               end else begin
                  link_tbl[tail_idx] = slot;
               end
               tail_idx = slot;
               releases = releases + 1;
               held     = held - cnt_type'(1);
            end
         end
      end
      r.alloc_total        = grants;
      r.free_total         = releases;
      r.blocks_outstanding = held;
      return r;
   endfunction

   always @(posedge clock) begin
      pool_result_type seen;
      pool_result_type want;
      if (reset) begin
         pool_base       = RST_BASE;
         pool_blk_size   = RST_SIZE;
         pool_item_count = RST_ITEMS;
         grants          = '0;
         releases        = '0;
         rebuild_free_list();
         due_results.delete();
         fail_count   = 0;
         report_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = {rsp_mon.status, rsp_mon.block_address, rsp_mon.alloc_total,
                    rsp_mon.free_total, rsp_mon.blocks_outstanding};
            if (due_results.size() == 0) begin
               fail_count++;
               if (report_count < 10) begin
                  $display("%0t: response beat with nothing due: status=%0d addr=%h",
                           $realtime, seen.status, seen.block_address);
                  report_count++;
               end
            end else begin
               want = due_results.pop_front();
               if (want !== seen) begin
                  fail_count++;
                  if (report_count < 10) begin
                     $display("%0t: expected status=%0d addr=%h allocs=%0d frees=%0d held=%0d",
                              $realtime, want.status, want.block_address, want.alloc_total,
                              want.free_total, want.blocks_outstanding);
                     $display("%0t: actual   status=%0d addr=%h allocs=%0d frees=%0d held=%0d",
                              $realtime, seen.status, seen.block_address, seen.alloc_total,
                              seen.free_total, seen.blocks_outstanding);
                     report_count++;
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            due_results.push_back(serve_request(req_mon.req_type, req_mon.free_address));
         if (csr_wr_en) begin
            case (csr_index)
               REG_BASE: begin
                  pool_base = csr_wdata;
                  rebuild_free_list();
               end
               REG_SIZE: begin
                  pool_blk_size = csr_wdata[SIZE_W-1:0];
                  rebuild_free_list();
               end
               REG_ITEMS: begin
                  pool_item_count = csr_wdata[CNT_W-1:0];
                  rebuild_free_list();
               end
               default: ;
            endcase
         end
      end
      pending = due_results.size();
   end

endmodule

/* dv/fixed_block_pool_allocator_tb.sv */
`timescale 1ns / 1ps
// Top of the fixed block pool allocator testbench: clock, reset, register setup and
// request/response traffic per phase; the pool checker does the comparing.
// Depends on fbpa_pkg, fbpa_req_if, fbpa_rsp_if, fbpa_pool_checker and the block.
module fixed_block_pool_allocator_tb;
   import fbpa_pkg::*;

   localparam csr_idx_type REG_SPARE    = 2'd3;
   localparam int          CYCLE_LIMIT  = 400_000;
   localparam int          DRAIN_CYCLES = 20;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   csr_idx_type csr_index;
   addr_type    csr_wdata;
   int          fail_count;
   int          pending;
   int          send_idle_pct;
   int          stall_pct;
   int          cycle_count;
   addr_type    live_blocks [$];
   logic        kinds_in_flight [$];
   addr_type    cur_base;
   int unsigned cur_size;
   int unsigned cur_count;

   fbpa_req_if req_chan ();
   fbpa_rsp_if rsp_chan ();

   fixed_block_pool_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   fbpa_pool_checker pool_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("fixed_block_pool_allocator regression: fail");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   // track granted blocks so that most frees hit a live block
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready && kinds_in_flight.size() != 0) begin
            if (kinds_in_flight.pop_front() == REQ_ALLOC && rsp_chan.status == ST_OK)
               live_blocks.push_back(rsp_chan.block_address);
         end
         if (req_chan.valid && req_chan.ready)
            kinds_in_flight.push_back(req_chan.req_type);
      end
   end

   task automatic send_beat(input logic kind, input addr_type addr);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.req_type     <= kind;
      req_chan.free_address <= addr;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic quiesce();
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic set_pool(input addr_type base, input addr_type size, input addr_type count);
      quiesce();
      csr_wr_en <= 1'b1;
      csr_index <= REG_BASE;
      csr_wdata <= base;
      @(negedge clock);
      csr_index <= REG_SIZE;
      csr_wdata <= size;
      @(negedge clock);
      csr_index <= REG_ITEMS;
      csr_wdata <= count;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_base  = base;
      cur_size  = (size[SIZE_W-1:0] == 0) ? 1 : size[SIZE_W-1:0];
      cur_count = (count[CNT_W-1:0] == 0) ? 1 :
                  (count[CNT_W-1:0] > MAX_ITEMS) ? MAX_ITEMS : count[CNT_W-1:0];
      live_blocks.delete();
   endtask

   task automatic poke_spare();
      quiesce();
      csr_wr_en <= 1'b1;
      csr_index <= REG_SPARE;
      csr_wdata <= $urandom();
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_beat();
      int unsigned pick;
      int unsigned slot;
      addr_type    a;
      pick = $urandom_range(99);
      if (pick < 45 || (pick < 85 && live_blocks.size() == 0)) begin
         send_beat(REQ_ALLOC, $urandom());
      end else if (pick < 85) begin
         slot = $urandom_range(live_blocks.size() - 1);
         a = live_blocks[slot] + $urandom_range(cur_size - 1);
         live_blocks.delete(slot);
         send_beat(REQ_FREE, a);
      end else begin
         case ($urandom_range(5))
            0: a = $urandom();
            1: a = cur_base - 1;
            2: a = cur_base + cur_size * cur_count;
            3: a = cur_base + cur_size * cur_count - 1;
            4: a = cur_base + $urandom_range(cur_size * cur_count - 1);
            default: a = cur_base;
         endcase
         send_beat(REQ_FREE, a);
      end
   endtask

   task automatic run_phase(input bit fresh, input addr_type base, input addr_type size,
                            input addr_type count, input int send_pct, input int stall,
                            input int beats);
      if (fresh) set_pool(base, size, count);
      else poke_spare();
      send_idle_pct = send_pct;
      stall_pct    <= stall;
      repeat (beats) random_beat();
   endtask

   initial begin
      reset                 <= 1'b1;
      csr_wr_en             <= 1'b0;
      csr_index             <= REG_BASE;
      csr_wdata             <= '0;
      req_chan.valid        <= 1'b0;
      req_chan.req_type     <= REQ_ALLOC;
      req_chan.free_address <= '0;
      stall_pct             <= 0;
      send_idle_pct = 0;
      cur_base      = RST_BASE;
      cur_size      = RST_SIZE;
      cur_count     = RST_ITEMS;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset configuration: grants, unaligned free, double free, range ends
      send_beat(REQ_ALLOC, 32'hFFFF_FFFF);
      send_beat(REQ_ALLOC, 32'h0000_0000);
      send_beat(REQ_FREE, 32'h0000_07FF);
      send_beat(REQ_FREE, 32'h0000_0000);
      send_beat(REQ_FREE, 32'h0002_0000);
      send_beat(REQ_FREE, 32'h0001_FFFF);
      send_beat(REQ_FREE, 32'hFFFF_FFFF);
      send_beat(REQ_FREE, 32'h0000_0800);
      send_beat(REQ_ALLOC, 32'h5555_5555);

      // two-block pool with zero size: exhaust, refill from empty list
      set_pool(32'h0000_0100, 32'h0000_0000, 32'd2);
      send_beat(REQ_ALLOC, 32'hAAAA_AAAA);
      send_beat(REQ_ALLOC, 32'h0000_0000);
      send_beat(REQ_ALLOC, 32'h0000_0000);
      send_beat(REQ_ALLOC, 32'h0000_0000);
      send_beat(REQ_FREE, 32'h0000_00FF);
      send_beat(REQ_FREE, 32'h0000_0102);
      send_beat(REQ_FREE, 32'h0000_0101);
      send_beat(REQ_ALLOC, 32'h0000_0000);
      send_beat(REQ_FREE, 32'h0000_0100);
      send_beat(REQ_FREE, 32'h0000_0101);
      send_beat(REQ_FREE, 32'h0000_0100);
      send_beat(REQ_ALLOC, 32'h0000_0000);
      send_beat(REQ_ALLOC, 32'h0000_0000);

      run_phase(1'b1, 32'h0000_0000, 32'd2048, 32'd64, 0, 0, 130);
      run_phase(1'b1, 32'hFFFF_FFF0, 32'd1, 32'd1, 53, 0, 80);
      run_phase(1'b1, 32'hFFF0_0000, 32'd65536, 32'd64, 0, 53, 130);
      run_phase(1'b1, $urandom(), 32'd0, 32'd127, 22, 22, 120);
      run_phase(1'b0, '0, '0, '0, 0, 0, 90);
      run_phase(1'b1, $urandom(), 32'h0001_FFFF, 32'd3, 53, 0, 100);
      run_phase(1'b1, 32'h0000_1000, 32'd3, 32'd5, 0, 53, 100);
      run_phase(1'b1, $urandom(), $urandom_range(65536, 1), $urandom_range(64, 1), 22, 22, 110);
      run_phase(1'b1, 32'h0000_0000, 32'd65536, 32'd0, 0, 0, 60);

      quiesce();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("fixed_block_pool_allocator regression: pass");
      else
         $display("fixed_block_pool_allocator regression: fail");
      $finish;
   end

endmodule
